// ===== src/assert_macros.svh =====
// Assertion macros used by the divider controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed in the divider.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed in the divider.");

`endif

// ===== src/sudm_pkg.sv =====
// Package with the types and constants of the 64-bit signed and unsigned divider.
package sudm_pkg;

   localparam int DEF_DATA_WIDTH = 64;
   localparam int FIELD_WIDTH    = 64;

   typedef struct packed {
      logic                   func;
      logic [FIELD_WIDTH-1:0] dividend;
      logic [FIELD_WIDTH-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] quotient;
      logic [FIELD_WIDTH-1:0] remainder;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX,
      ST_DONE
   } state_type;

endpackage

// ===== src/sudm_ctrl.sv =====
// Controller state machine that sequences the load, iterations and sign fix-up.
`include "assert_macros.svh"

module sudm_ctrl #(
   parameter int DATA_WIDTH = sudm_pkg::DEF_DATA_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output sudm_pkg::cmd_type cmd
);
   import sudm_pkg::*;

   localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

   state_type     state_ff;
   state_type     state_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          last;

   assign last = (count_ff == CW'(DATA_WIDTH - 1));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (start) begin
               state_in = ST_RUN;
            end else begin
               state_in = ST_IDLE;
            end
            count_in = '0;
         end
         ST_RUN: begin
            if (last) begin
               state_in = ST_FIX;
               count_in = '0;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_FIX: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_IDLE;
            count_in = '0;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b0;
      rsp_valid  = 1'b0;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_RUN: begin
            busy     = 1'b1;
            cmd.step = 1'b1;
         end
         ST_FIX: begin
            busy       = 1'b1;
            cmd.finish = 1'b1;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            cmd.load  = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_NEXT(a_accept_runs, clock, reset, start && !busy, state_ff == ST_RUN && count_ff == '0)
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid || $past(start))
   `ASSERT_SAME(a_fix_count_clear, clock, reset, state_ff == ST_FIX, count_ff == '0)
   `ASSERT_NEXT(a_fix_then_done, clock, reset, cmd.finish, rsp_valid)

endmodule

// ===== src/sudm_dpath.sv =====
// Datapath with the operand magnitudes, the shift-subtract step and the result register.
module sudm_dpath #(
   parameter int DATA_WIDTH = sudm_pkg::DEF_DATA_WIDTH
) (
   input  logic              clock,
   input  sudm_pkg::cmd_type cmd,
   input  sudm_pkg::req_type req_data,
   output sudm_pkg::rsp_type rsp_data
);
   import sudm_pkg::*;

   localparam int W = DATA_WIDTH;

   logic [W-1:0] num_ff;
   logic [W-1:0] den_ff;
   logic [W-1:0] part_ff;
   logic         neg_q_ff;
   logic         neg_r_ff;
   logic         dzero_ff;
   rsp_type      rsp_ff;

   logic [W-1:0] op_n;
   logic [W-1:0] op_d;
   logic         neg_n;
   logic         neg_d;
   logic [W:0]   shifted;
   logic [W:0]   diff;
   logic         ge;
   logic [W-1:0] q_fix;
   logic [W-1:0] r_fix;

   assign op_n  = req_data.dividend[W-1:0];
   assign op_d  = req_data.divisor[W-1:0];
   assign neg_n = req_data.func & op_n[W-1];
   assign neg_d = req_data.func & op_d[W-1];

   assign shifted = {part_ff, num_ff[W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = (shifted >= {1'b0, den_ff});

   assign q_fix = neg_q_ff ? (W'(0) - num_ff) : num_ff;
   assign r_fix = neg_r_ff ? (W'(0) - part_ff) : part_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff   <= neg_n ? (W'(0) - op_n) : op_n;
         den_ff   <= neg_d ? (W'(0) - op_d) : op_d;
         part_ff  <= '0;
         neg_q_ff <= neg_n ^ neg_d;
         neg_r_ff <= neg_n;
         dzero_ff <= (op_d == '0);
      end else if (cmd.step) begin
         num_ff  <= {num_ff[W-2:0], ge};
         part_ff <= ge ? diff[W-1:0] : shifted[W-1:0];
      end
      if (cmd.finish) begin
         if (dzero_ff) begin
            rsp_ff.quotient  <= '0;
            rsp_ff.remainder <= '0;
         end else begin
            rsp_ff.quotient  <= FIELD_WIDTH'(q_fix);
            rsp_ff.remainder <= FIELD_WIDTH'(r_fix);
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== src/signed_unsigned_divmod_64.sv =====
// Top level of the signed and unsigned radix-2 restoring divider.
// A request transfer happens at a rising clock edge where start is high and busy
// is low; req_data then carries the signedness selector, dividend and divisor.
// The quotient and remainder appear on rsp_data, marked by rsp_valid, which is
// high for exactly one cycle, and that cycle is the response transfer.
// From the request edge, the shift-subtract loop runs in the datapath, then the
// sign fix-up writes the result register, and then the response is strobed.
// A new request is taken during the strobe cycle, but none while busy, so a
// division completes before the next one starts; the single shared subtractor
// handles one quotient bit per cycle.
// Signed mode truncates toward zero, the remainder takes the dividend sign, a
// zero divisor gives zero for both results, and the most negative value divided
// by minus one returns the most negative value.
// Synchronous reset returns the controller to idle and drops any division in
// progress. The receiver cannot stall, so a response that is not taken in its
// strobe cycle is lost.
module signed_unsigned_divmod_64 #(
   parameter int DATA_WIDTH = sudm_pkg::DEF_DATA_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sudm_pkg::req_type req_data,
   output logic              rsp_valid,
   output sudm_pkg::rsp_type rsp_data
);
   import sudm_pkg::*;

   cmd_type cmd;

   sudm_ctrl #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .cmd      (cmd)
   );

   sudm_dpath #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_dpath (
      .clock   (clock),
      .cmd     (cmd),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 64-bit signed and unsigned divider.
module testbench;
   import sudm_pkg::*;

   localparam int DIV_WIDTH = 64;
   localparam int LATENCY = DIV_WIDTH + 2;
   localparam bit [DIV_WIDTH-1:0] ALL_ONES = {DIV_WIDTH{1'b1}};
   localparam bit [DIV_WIDTH-1:0] MOST_NEG = {1'b1, {(DIV_WIDTH-1){1'b0}}};
   localparam bit [DIV_WIDTH-1:0] MOST_POS = {1'b0, {(DIV_WIDTH-1){1'b1}}};
   localparam bit FUNC_UNSIGNED = 1'b0;
   localparam bit FUNC_SIGNED = 1'b1;

   typedef struct {
      req_type operands;
      rsp_type outcome;
   } division_entry_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;

   division_entry_type pending_divisions[$];
   int num_sent;
   int num_checked;
   int num_signed;
   int num_zero_divisor;
   int num_errors;

   signed_unsigned_divmod_64 u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   function automatic rsp_type truncated_divide(req_type operands);
      bit [DIV_WIDTH-1:0] num_mag;
      bit [DIV_WIDTH-1:0] den_mag;
      bit [DIV_WIDTH-1:0] quo;
      bit [DIV_WIDTH-1:0] rem;
      bit num_neg;
      bit den_neg;
      rsp_type result;
      num_mag = operands.dividend[DIV_WIDTH-1:0];
      den_mag = operands.divisor[DIV_WIDTH-1:0];
      num_neg = (operands.func == FUNC_SIGNED) && num_mag[DIV_WIDTH-1];
      den_neg = (operands.func == FUNC_SIGNED) && den_mag[DIV_WIDTH-1];
      if (num_neg) begin
         num_mag = '0 - num_mag;
      end
      if (den_neg) begin
         den_mag = '0 - den_mag;
      end
      if (den_mag == '0) begin
         quo = '0;
         rem = '0;
      end else begin
         quo = num_mag / den_mag;
         rem = num_mag % den_mag;
      end
      if (num_neg != den_neg) begin
         quo = '0 - quo;
      end
      if (num_neg) begin
         rem = '0 - rem;
      end
      result.quotient = quo;
      result.remainder = rem;
      return result;
   endfunction

   function automatic bit [DIV_WIDTH-1:0] random_operand();
      bit [DIV_WIDTH-1:0] value;
      value = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         4, 5: begin
            value = value >> $urandom_range(0, DIV_WIDTH - 1);
         end
         6: begin
            value = '0 - (value >> $urandom_range(1, DIV_WIDTH - 1));
         end
         7: begin
            case ($urandom_range(0, 5))
               0: value = '0;
               1: value = DIV_WIDTH'(1);
               2: value = ALL_ONES;
               3: value = MOST_NEG;
               4: value = MOST_POS;
               default: value = ALL_ONES - DIV_WIDTH'(1);
            endcase
         end
         8: begin
            value = DIV_WIDTH'(1);
            value = value << $urandom_range(0, DIV_WIDTH - 1);
         end
         9: begin
            value = DIV_WIDTH'($urandom_range(0, 255));
         end
         default: begin
         end
      endcase
      return value;
   endfunction

   task automatic send_division(input bit func, input bit [DIV_WIDTH-1:0] dividend,
                                input bit [DIV_WIDTH-1:0] divisor);
      req_type operands;
      division_entry_type entry;
      operands.func = func;
      operands.dividend = dividend;
      operands.divisor = divisor;
      start <= 1'b1;
      req_data <= operands;
      do begin
         @(posedge clock);
      end while (busy);
      entry.operands = operands;
      entry.outcome = truncated_divide(operands);
      pending_divisions.push_back(entry);
      num_sent++;
      if (func == FUNC_SIGNED) begin
         num_signed++;
      end
      if (divisor == '0) begin
         num_zero_divisor++;
      end
   endtask

   task automatic pause_requests(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic test_unsigned_edges();
      send_division(FUNC_UNSIGNED, '0, '0);
      send_division(FUNC_UNSIGNED, ALL_ONES, '0);
      send_division(FUNC_UNSIGNED, ALL_ONES, 64'd1);
      send_division(FUNC_UNSIGNED, ALL_ONES, ALL_ONES);
      send_division(FUNC_UNSIGNED, 64'd1, ALL_ONES);
      send_division(FUNC_UNSIGNED, ALL_ONES, MOST_NEG);
      send_division(FUNC_UNSIGNED, MOST_NEG, ALL_ONES);
      send_division(FUNC_UNSIGNED, 64'd1000, 64'd7);
      send_division(FUNC_UNSIGNED, 64'd5, 64'd9);
      send_division(FUNC_UNSIGNED, '0, ALL_ONES);
      pause_requests(3);
   endtask

   task automatic test_signed_edges();
      send_division(FUNC_SIGNED, MOST_NEG, ALL_ONES);
      send_division(FUNC_SIGNED, MOST_NEG, 64'd1);
      send_division(FUNC_SIGNED, MOST_NEG, MOST_NEG);
      send_division(FUNC_SIGNED, MOST_POS, MOST_NEG);
      send_division(FUNC_SIGNED, MOST_NEG, '0);
      send_division(FUNC_SIGNED, ALL_ONES, '0);
      send_division(FUNC_SIGNED, '0 - 64'd7, 64'd2);
      send_division(FUNC_SIGNED, 64'd7, '0 - 64'd2);
      send_division(FUNC_SIGNED, '0 - 64'd7, '0 - 64'd2);
      send_division(FUNC_SIGNED, 64'd7, 64'd2);
      send_division(FUNC_SIGNED, MOST_POS, ALL_ONES);
      send_division(FUNC_SIGNED, '0, ALL_ONES);
      pause_requests(5);
   endtask

   task automatic test_random_bursts(input int count);
      int burst_len;
      int issued;
      bit [DIV_WIDTH-1:0] divisor;
      issued = 0;
      while (issued < count) begin
         burst_len = $urandom_range(1, 12);
         repeat (burst_len) begin
            divisor = ($urandom_range(0, 15) == 0) ? '0 : random_operand();
            send_division(1'($urandom_range(0, 1)), random_operand(), divisor);
            issued++;
         end
         if ($urandom_range(0, 3) != 0) begin
            pause_requests($urandom_range(1, LATENCY + 10));
         end
      end
   endtask

   task automatic test_back_to_back(input int count);
      repeat (count) begin
         send_division(1'($urandom_range(0, 1)), random_operand(), random_operand());
      end
   endtask

   always @(posedge clock) begin
      division_entry_type entry;
      if (!reset && rsp_valid) begin
         if (pending_divisions.size() == 0) begin
            $display("%0t: result transfer with no division pending: %h %h", $time,
                     rsp_data.quotient, rsp_data.remainder);
            num_errors++;
         end else begin
            entry = pending_divisions.pop_front();
            num_checked++;
            if (rsp_data.quotient !== entry.outcome.quotient) begin
               $display("%0t: quotient of %h / %h (func %0d): expected %h, actual %h",
                        $time, entry.operands.dividend, entry.operands.divisor,
                        entry.operands.func, entry.outcome.quotient, rsp_data.quotient);
               num_errors++;
            end
            if (rsp_data.remainder !== entry.outcome.remainder) begin
               $display("%0t: remainder of %h / %h (func %0d): expected %h, actual %h",
                        $time, entry.operands.dividend, entry.operands.divisor,
                        entry.operands.func, entry.outcome.remainder, rsp_data.remainder);
               num_errors++;
            end
         end
      end
   end

   initial begin
      num_sent = 0;
      num_checked = 0;
      num_signed = 0;
      num_zero_divisor = 0;
      num_errors = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unsigned_edges();
      test_signed_edges();
      test_random_bursts(1000);
      test_back_to_back(200);
      start <= 1'b0;
      while (pending_divisions.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
      $display("Sent %0d divisions and checked %0d results.", num_sent, num_checked);
      $display("Of these, %0d were signed and %0d had a zero divisor.", num_signed,
               num_zero_divisor);
      if (num_errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("simulation failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+src
src/sudm_pkg.sv
src/sudm_ctrl.sv
src/sudm_dpath.sv
src/signed_unsigned_divmod_64.sv
tb/testbench.sv
